### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/drl_pkg.sv
`default_nettype none

package drl_pkg;

    localparam int RING_DEPTH  = 512;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int COUNT_OUT_W = 9;
    localparam int EXT_W       = PTR_W + COUNT_OUT_W;
    localparam int CD_W        = 11;
    localparam int FLIP_SHIFT  = 20;
    localparam int RND_HI_W    = 32 - FLIP_SHIFT;
    localparam int FLIP_SPAN   = 700;

    localparam logic [31:0]     LCG_MUL   = 32'd1664525;
    localparam logic [31:0]     LCG_ADD   = 32'd1013904223;
    localparam logic [CD_W-1:0] FLIP_BASE = CD_W'(600);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_BYTE  = 3'd1,
        CMD_POP   = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        LINK_OFF       = 2'd0,
        LINK_SEARCHING = 2'd1,
        LINK_CONNECTED = 2'd2
    } t_link;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        t_link                  link_status;
        logic                   host_role;
        logic                   is_host;
        logic                   role_flipped;
        logic                   byte_accepted;
        logic                   data_valid;
        logic [COUNT_OUT_W-1:0] bytes_waiting;
    } t_item_res;

    // 600 + (rnd >> 20) mod 700, by restoring subtraction of 2800, 1400, 700
    function automatic logic [CD_W-1:0] flip_reload(input logic [31:0] rnd);
        logic [RND_HI_W-1:0] v;
        v = rnd[31:FLIP_SHIFT];
        if (v >= RND_HI_W'(4 * FLIP_SPAN)) begin
            v = v - RND_HI_W'(4 * FLIP_SPAN);
        end
        if (v >= RND_HI_W'(2 * FLIP_SPAN)) begin
            v = v - RND_HI_W'(2 * FLIP_SPAN);
        end
        if (v >= RND_HI_W'(FLIP_SPAN)) begin
            v = v - RND_HI_W'(FLIP_SPAN);
        end
        return FLIP_BASE + CD_W'(v);
    endfunction

endpackage

`default_nettype wire

### rtl/drl_ring_ram.sv
`default_nettype none

module drl_ring_ram (
    input  wire logic              i_clk,
    input  wire drl_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [drl_pkg::RING_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/drl_ctrl.sv
`default_nettype none

module drl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [2:0]         i_command,
    input  wire logic [7:0]         i_byte_in,
    input  wire logic               i_peer_ready,
    input  wire logic [31:0]        i_seed,
    output drl_pkg::t_ram_req       o_ram,
    output drl_pkg::t_item_res      o_res
);

    logic [drl_pkg::PTR_W-1:0] r_wr, n_wr;
    logic [drl_pkg::PTR_W-1:0] r_rd, n_rd;
    logic [31:0]               r_rng, n_rng;
    logic [drl_pkg::CD_W-1:0]  r_cd, n_cd;
    logic                      r_running, n_running;
    logic                      r_host, n_host;
    logic                      r_linked, n_linked;

    logic [drl_pkg::PTR_W-1:0] wr_inc;
    logic [drl_pkg::PTR_W-1:0] rd_inc;
    logic                      ring_full;
    logic                      ring_empty;
    logic [31:0]               mul_op;
    logic [31:0]               lcg_next;
    logic [drl_pkg::CD_W-1:0]  cd_dec;
    logic [drl_pkg::PTR_W-1:0] count;
    logic [drl_pkg::EXT_W-1:0] count_ext;
    logic                      do_write;
    logic                      do_pop;
    drl_pkg::t_cmd             cmd;

    assign cmd        = drl_pkg::t_cmd'(i_command);
    assign wr_inc     = (r_wr == drl_pkg::PTR_W'(drl_pkg::RING_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_inc     = (r_rd == drl_pkg::PTR_W'(drl_pkg::RING_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign ring_full  = (wr_inc == r_rd);
    assign ring_empty = (r_wr == r_rd);
    assign cd_dec     = (r_cd != '0) ? r_cd - 1'b1 : r_cd;

    // one shared generator step: from the seed on start, else from the held word
    assign mul_op   = (cmd == drl_pkg::CMD_START) ? (i_seed | 32'd1) : r_rng;
    assign lcg_next = 32'(mul_op * drl_pkg::LCG_MUL) + drl_pkg::LCG_ADD;

    assign do_write = i_accept && (cmd == drl_pkg::CMD_BYTE) && r_running && !ring_full;
    assign do_pop   = i_accept && (cmd == drl_pkg::CMD_POP) && !ring_empty;

    always_comb begin
        n_wr      = r_wr;
        n_rd      = r_rd;
        n_rng     = r_rng;
        n_cd      = r_cd;
        n_running = r_running;
        n_host    = r_host;
        n_linked  = r_linked;
        if (i_accept) begin
            case (cmd)
                drl_pkg::CMD_TICK: begin
                    if (r_running) begin
                        n_cd     = cd_dec;
                        n_linked = i_peer_ready;
                        if (!i_peer_ready && cd_dec == '0) begin
                            n_host = !r_host;
                            n_rng  = lcg_next;
                            n_cd   = drl_pkg::flip_reload(lcg_next);
                        end
                    end
                end
                drl_pkg::CMD_BYTE: begin
                    if (do_write) begin
                        n_wr = wr_inc;
                    end
                end
                drl_pkg::CMD_POP: begin
                    if (do_pop) begin
                        n_rd = rd_inc;
                    end
                end
                drl_pkg::CMD_START: begin
                    if (!r_running) begin
                        n_running = 1'b1;
                        n_linked  = 1'b0;
                        n_wr      = '0;
                        n_rd      = '0;
                        n_host    = 1'b0;
                        n_rng     = lcg_next;
                        n_cd      = drl_pkg::flip_reload(lcg_next);
                    end
                end
                drl_pkg::CMD_STOP: begin
                    if (r_running) begin
                        n_running = 1'b0;
                        n_linked  = 1'b0;
                        n_host    = 1'b0;
                        n_wr      = '0;
                        n_rd      = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_rng     <= '0;
            r_cd      <= '0;
            r_running <= 1'b0;
            r_host    <= 1'b0;
            r_linked  <= 1'b0;
        end else begin
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_rng     <= n_rng;
            r_cd      <= n_cd;
            r_running <= n_running;
            r_host    <= n_host;
            r_linked  <= n_linked;
        end
    end

    assign count = (n_wr >= n_rd) ? n_wr - n_rd
                                  : drl_pkg::PTR_W'(drl_pkg::RING_DEPTH) + n_wr - n_rd;
    assign count_ext = drl_pkg::EXT_W'(count);

    // a single item never writes and reads the ring, so no same-entry overlap
    assign o_ram.wr_en   = do_write;
    assign o_ram.wr_addr = r_wr;
    assign o_ram.wr_data = i_byte_in;
    assign o_ram.rd_en   = do_pop;
    assign o_ram.rd_addr = r_rd;

    always_comb begin
        if (!n_running) begin
            o_res.link_status = drl_pkg::LINK_OFF;
        end else if (n_linked) begin
            o_res.link_status = drl_pkg::LINK_CONNECTED;
        end else begin
            o_res.link_status = drl_pkg::LINK_SEARCHING;
        end
        o_res.host_role     = n_host;
        o_res.is_host       = n_running && n_linked && n_host;
        o_res.role_flipped  = (n_host != r_host);
        o_res.byte_accepted = do_write;
        o_res.data_valid    = do_pop;
        o_res.bytes_waiting = count_ext[drl_pkg::COUNT_OUT_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/dual_role_link_discovery_unit.sv
`default_nettype none

// Dual-role link discovery controller with a 512-byte receive ring. One item
// is taken per clock cycle while the output is not stalled, with no clearing
// pass after reset. Accepting an item updates the control state and issues
// the ring access (one write port, one read port, registered read data); the
// s1 register then holds the result while the popped byte comes out of the
// ring, and an output register carries it to the consumer. Commands: 0
// one-millisecond tick (peer_ready sampled), 1 received byte, 2 pop, 3 start
// (seed used), 4 stop; other codes only report status.
module dual_role_link_discovery_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_peer_ready,
    input  wire logic [31:0] i_seed,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_link_status,
    output logic             o_host_role,
    output logic             o_is_host,
    output logic             o_role_flipped,
    output logic             o_byte_accepted,
    output logic [7:0]       o_data_out,
    output logic             o_data_valid,
    output logic [8:0]       o_bytes_waiting
);

    logic                  in_accept;
    logic                  s1_adv;
    drl_pkg::t_ram_req     ram_req;
    drl_pkg::t_item_res    item_res;
    logic [7:0]            ram_rdata;

    logic                  r_s1_valid, n_s1_valid;
    drl_pkg::t_item_res    r_s1;
    logic                  r_out_valid, n_out_valid;
    drl_pkg::t_item_res    r_out;
    logic [7:0]            r_out_data;

    assign s1_adv    = !r_out_valid || i_ready;
    assign o_ready   = !r_s1_valid || s1_adv;
    assign in_accept = i_valid && o_ready;

    drl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_command    (i_command),
        .i_byte_in    (i_byte_in),
        .i_peer_ready (i_peer_ready),
        .i_seed       (i_seed),
        .o_ram        (ram_req),
        .o_res        (item_res)
    );

    drl_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= item_res;
        end
        if (s1_adv && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.data_valid ? ram_rdata : 8'd0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_link_status   = r_out.link_status;
    assign o_host_role     = r_out.host_role;
    assign o_is_host       = r_out.is_host;
    assign o_role_flipped  = r_out.role_flipped;
    assign o_byte_accepted = r_out.byte_accepted;
    assign o_data_out      = r_out_data;
    assign o_data_valid    = r_out.data_valid;
    assign o_bytes_waiting = r_out.bytes_waiting;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, in_accept, r_s1_valid, "accepted item lost")
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1), "stalled stage changed")
    `ASSERT_SAME(a_is_host_conn, i_clk, i_rst_n, o_valid && o_is_host, o_host_role && o_link_status == drl_pkg::LINK_CONNECTED, "is_host without connected host")
    `ASSERT_SAME(a_pop_data, i_clk, i_rst_n, o_valid && !o_data_valid, o_data_out == 8'd0, "data without pop")

endmodule

`default_nettype wire
